FILE: sv/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared sizes, codes and types of the box table: action and status codes,
// the stored box record and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package bct_pkg;

   // table and field sizes
   localparam int CAPACITY   = 32;
   localparam int ID_BITS    = 16;
   localparam int COORD_BITS = 16;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // action codes
   localparam logic [2:0] ACT_REGISTER   = 3'd0;
   localparam logic [2:0] ACT_UNREGISTER = 3'd1;
   localparam logic [2:0] ACT_GET        = 3'd2;
   localparam logic [2:0] ACT_SET        = 3'd3;
   localparam logic [2:0] ACT_OVERLAP    = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISS      = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

   // one stored box, Q12.4 corners
   typedef struct packed {
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
   } box_type;

   // commands broadcast along the chain
   typedef struct packed {
      logic capture;   // latch compare results
      logic shift_en;  // close the gap behind a removed entry
      logic set_en;    // overwrite the box of the matching entry
      logic drain;     // hand out the first pending overlap hit
   } cell_ctrl_type;

endpackage

FILE: sv/bct_cell.sv
// ----------------------------------------------------------------------------
// bct_cell
// One slot of the table. Holds an id and a box, compares them against the
// query, and passes selection tokens and entry data to its neighbours.
// ----------------------------------------------------------------------------
module bct_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  bct_pkg::cell_ctrl_type          ctrl,
   input  logic                            occupied,
   input  logic                            append_sel,
   input  logic [bct_pkg::ID_BITS-1:0]     q_id,
   input  bct_pkg::box_type                q_box,
   input  logic [bct_pkg::ID_BITS-1:0]     new_id,
   input  logic [bct_pkg::ID_BITS-1:0]     nbr_id,
   input  bct_pkg::box_type                nbr_box,
   input  logic                            seen_in,
   input  logic                            taken_in,
   input  logic                            more_in,
   output logic                            seen_out,
   output logic                            taken_out,
   output logic                            more_out,
   output logic                            match,
   output logic                            pick,
   output logic [bct_pkg::ID_BITS-1:0]     id_out,
   output bct_pkg::box_type                box_out
);

   logic [bct_pkg::ID_BITS-1:0] id_ff, id_in;
   bct_pkg::box_type            box_ff, box_in;
   logic                        match_ff, match_in;
   logic                        hit_ff, hit_in;
   logic                        id_eq, overlap;

   // compare against the query; touching boxes count as overlapping
   assign id_eq   = (id_ff == q_id);
   assign overlap = (box_ff.min_x <= q_box.max_x) && (box_ff.max_x >= q_box.min_x) &&
                    (box_ff.min_y <= q_box.max_y) && (box_ff.max_y >= q_box.min_y);

   // tokens: first match onwards, first pending hit, later pending hits
   assign seen_out  = seen_in | match_ff;
   assign pick      = hit_ff & ~taken_in;
   assign taken_out = taken_in | hit_ff;
   assign more_out  = more_in | (hit_ff & taken_in);

   assign match   = match_ff;
   assign id_out  = id_ff;
   assign box_out = box_ff;

   // entry update: shift from the right-hand neighbour, append or overwrite
   always_comb begin
      id_in    = id_ff;
      box_in   = box_ff;
      match_in = match_ff;
      hit_in   = hit_ff;
      if (ctrl.capture) begin
         match_in = occupied & id_eq;
         hit_in   = occupied & overlap;
      end
      if (ctrl.shift_en && seen_out) begin
         id_in  = nbr_id;
         box_in = nbr_box;
      end else if (append_sel) begin
         id_in  = new_id;
         box_in = q_box;
      end else if (ctrl.set_en && match_ff) begin
         box_in = q_box;
      end
      if (ctrl.drain && pick) begin
         hit_in = 1'b0;
      end
   end

   // hold entry data; compare flags are cleared by reset
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      box_ff <= box_in;
      if (reset) begin
         match_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         match_ff <= match_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

FILE: sv/box_collider_table_with_overlap_query.sv
// ----------------------------------------------------------------------------
// box_collider_table_with_overlap_query
// Id-sorted table of 2D boxes held in a chain of cells, with register,
// unregister, get, set and overlap query actions.
// ----------------------------------------------------------------------------
//  Channel  Ports                                        Direction
//  req      req_valid/req_ready, action, id, box         in
//  rsp      rsp_valid/rsp_ready, status, id, box, last   out
//
//  A request is taken in S_IDLE, compared in all cells in S_LOOK, and
//  answered in S_EMIT: one result for the other actions, and one per hit
//  for an overlap query (hits leave one per cycle while the output is free).
//  Reset empties the table and restarts the id counter at zero.
//  A stalled result holds the answer stage; a new request is taken while a
//  result still waits in the output register.
// ----------------------------------------------------------------------------
module box_collider_table_with_overlap_query (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_action,
   input  logic [bct_pkg::ID_BITS-1:0]         req_id,
   input  logic signed [bct_pkg::COORD_BITS-1:0] req_min_x,
   input  logic signed [bct_pkg::COORD_BITS-1:0] req_min_y,
   input  logic signed [bct_pkg::COORD_BITS-1:0] req_max_x,
   input  logic signed [bct_pkg::COORD_BITS-1:0] req_max_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [bct_pkg::ID_BITS-1:0]         rsp_result_id,
   output logic signed [bct_pkg::COORD_BITS-1:0] rsp_out_min_x,
   output logic signed [bct_pkg::COORD_BITS-1:0] rsp_out_min_y,
   output logic signed [bct_pkg::COORD_BITS-1:0] rsp_out_max_x,
   output logic signed [bct_pkg::COORD_BITS-1:0] rsp_out_max_y,
   output logic                                rsp_last
);

   localparam int CAP = bct_pkg::CAPACITY;
   localparam int IDW = bct_pkg::ID_BITS;
   localparam int CNW = bct_pkg::COUNT_BITS;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT} state_type;

   state_type              state_ff, state_in;
   logic [2:0]             q_action_ff, q_action_in;
   logic [IDW-1:0]         q_id_ff, q_id_in;
   bct_pkg::box_type       q_box_ff, q_box_in;
   logic [CNW-1:0]         count_ff, count_in;
   logic [IDW:0]           next_id_ff, next_id_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [IDW-1:0]         rid_ff, rid_in;
   bct_pkg::box_type       obox_ff, obox_in;
   logic                   last_ff, last_in;

   bct_pkg::cell_ctrl_type ctrl;
   logic                   append_en;
   logic                   out_free;

   logic [CAP-1:0]         occupied, append_sel, match, pick;
   logic [CAP:0]           seen_chain, taken_chain, more_chain;
   logic [IDW-1:0]         cell_id [CAP];
   bct_pkg::box_type       cell_box [CAP];
   logic [IDW-1:0]         pick_id;
   bct_pkg::box_type       match_box;
   logic                   any_match, any_hit, more_hits;

   assign seen_chain[0]  = 1'b0;
   assign taken_chain[0] = 1'b0;
   assign more_chain[0]  = 1'b0;

   // chain of table cells
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [IDW-1:0]   nbr_id;
      bct_pkg::box_type nbr_box;

      assign occupied[i]   = (CNW'(i) < count_ff);
      assign append_sel[i] = append_en & (count_ff == CNW'(i));

      if (i == CAP - 1) begin : g_end
         assign nbr_id  = cell_id[i];
         assign nbr_box = cell_box[i];
      end else begin : g_mid
         assign nbr_id  = cell_id[i+1];
         assign nbr_box = cell_box[i+1];
      end

      bct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .occupied   (occupied[i]),
         .append_sel (append_sel[i]),
         .q_id       (q_id_ff),
         .q_box      (q_box_ff),
         .new_id     (next_id_ff[IDW-1:0]),
         .nbr_id     (nbr_id),
         .nbr_box    (nbr_box),
         .seen_in    (seen_chain[i]),
         .taken_in   (taken_chain[i]),
         .more_in    (more_chain[i]),
         .seen_out   (seen_chain[i+1]),
         .taken_out  (taken_chain[i+1]),
         .more_out   (more_chain[i+1]),
         .match      (match[i]),
         .pick       (pick[i]),
         .id_out     (cell_id[i]),
         .box_out    (cell_box[i])
      );
   end

   assign any_match = seen_chain[CAP];
   assign any_hit   = taken_chain[CAP];
   assign more_hits = more_chain[CAP];

   // select the picked hit's id and the matched box
   always_comb begin
      pick_id   = '0;
      match_box = '0;
      for (int k = 0; k < CAP; k++) begin
         pick_id         = pick_id | (cell_id[k] & {IDW{pick[k]}});
         match_box.min_x = match_box.min_x | (cell_box[k].min_x & {bct_pkg::COORD_BITS{match[k]}});
         match_box.min_y = match_box.min_y | (cell_box[k].min_y & {bct_pkg::COORD_BITS{match[k]}});
         match_box.max_x = match_box.max_x | (cell_box[k].max_x & {bct_pkg::COORD_BITS{match[k]}});
         match_box.max_y = match_box.max_y | (cell_box[k].max_y & {bct_pkg::COORD_BITS{match[k]}});
      end
   end

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // sequence each request: take, compare, answer
   always_comb begin
      state_in     = state_ff;
      q_action_in  = q_action_ff;
      q_id_in      = q_id_ff;
      q_box_in     = q_box_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      obox_in      = obox_ff;
      last_in      = last_ff;
      ctrl         = '0;
      append_en    = 1'b0;

      // drop a result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_action_in    = req_action;
               q_id_in        = req_id;
               q_box_in.min_x = req_min_x;
               q_box_in.min_y = req_min_y;
               q_box_in.max_x = req_max_x;
               q_box_in.max_y = req_max_y;
               if (req_action inside {[bct_pkg::ACT_REGISTER:bct_pkg::ACT_OVERLAP]}) begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            ctrl.capture = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rid_in       = q_id_ff;
               obox_in      = '0;
               last_in      = 1'b1;
               status_in    = bct_pkg::STAT_OK;
               state_in     = S_IDLE;
               case (q_action_ff)
                  bct_pkg::ACT_REGISTER: begin
                     rid_in = '0;
                     if (count_ff == CNW'(CAP)) begin
                        status_in = bct_pkg::STAT_FULL;
                     end else if (next_id_ff[IDW]) begin
                        status_in = bct_pkg::STAT_EXHAUSTED;
                     end else begin
                        append_en  = 1'b1;
                        rid_in     = next_id_ff[IDW-1:0];
                        count_in   = count_ff + CNW'(1);
                        next_id_in = next_id_ff + (IDW+1)'(1);
                     end
                  end
                  bct_pkg::ACT_UNREGISTER: begin
                     if (any_match) begin
                        ctrl.shift_en = 1'b1;
                        count_in      = count_ff - CNW'(1);
                     end else begin
                        status_in = bct_pkg::STAT_MISS;
                     end
                  end
                  bct_pkg::ACT_GET: begin
                     if (any_match) begin
                        obox_in = match_box;
                     end else begin
                        status_in = bct_pkg::STAT_MISS;
                     end
                  end
                  bct_pkg::ACT_SET: begin
                     if (any_match) begin
                        ctrl.set_en = 1'b1;
                     end else begin
                        status_in = bct_pkg::STAT_MISS;
                     end
                  end
                  bct_pkg::ACT_OVERLAP: begin
                     if (any_hit) begin
                        ctrl.drain = 1'b1;
                        rid_in     = pick_id;
                        last_in    = ~more_hits;
                        if (more_hits) begin
                           state_in = S_EMIT;
                        end
                     end else begin
                        status_in = bct_pkg::STAT_MISS;
                        rid_in    = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff & ~rsp_ready;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state, table bookkeeping and the output register
   always_ff @(posedge clock) begin
      q_action_ff <= q_action_in;
      q_id_ff     <= q_id_in;
      q_box_ff    <= q_box_in;
      status_ff   <= status_in;
      rid_ff      <= rid_in;
      obox_ff     <= obox_in;
      last_ff     <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_out_min_x = obox_ff.min_x;
   assign rsp_out_min_y = obox_ff.min_y;
   assign rsp_out_max_x = obox_ff.max_x;
   assign rsp_out_max_y = obox_ff.max_y;
   assign rsp_last      = last_ff;

endmodule
